FILE: hdl/chip8_instruction_core_unit_assert.svh
// Assertion macros for the CHIP-8 instruction core.
// Included by the top level, which checks its own logic.
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define C8_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define C8_ASSERT_IMPL(label, clk, rst_n, a, c)
`define C8_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/c8_pkg.sv
// Package for the CHIP-8 instruction core: payload types, constants, font.
// No dependencies.
package c8_pkg;

    localparam int FONT_BASE     = 80;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int SI_W          = $clog2(STACK_DEPTH);
    localparam logic [11:0] PROGRAM_START = 12'h200;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_EXEC = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_UNK   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] load_addr;
        logic [7:0]  load_data;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } t_in;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] fetched_opcode;
        logic [1:0]  status;
        logic        collision;
        logic [63:0] display_row;
        logic [7:0]  sound_level;
    } t_out;

    function automatic logic [7:0] font_byte(input logic [6:0] k);
        logic [7:0] g [0:79];
        g = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
              8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
              8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
        return (k < 7'd80) ? g[k] : 8'h00;
    endfunction

endpackage

FILE: hdl/c8_mem.sv
// Main memory of the CHIP-8 core: 4096 bytes, one port, registered read.
// A clearing pass after reset writes the font and zeros. Uses c8_pkg.
module c8_mem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [11:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic [7:0]  o_rdata,
    output logic        o_busy
);
    import c8_pkg::*;

    logic [7:0]  r_mem [0:4095];
    logic [12:0] r_clr;
    logic [11:0] w_addr;
    logic [7:0]  w_data;
    logic        w_we;
    logic [11:0] w_off;

    assign o_busy = !r_clr[12];
    assign w_off  = r_clr[11:0] - 12'(FONT_BASE);
    assign w_addr = o_busy ? r_clr[11:0] : i_addr;
    assign w_we   = o_busy | i_we;
    assign w_data = o_busy ? ((r_clr[11:0] >= 12'(FONT_BASE) && w_off < 12'd80)
                              ? font_byte(w_off[6:0]) : 8'h00) : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (o_busy) begin
            r_clr <= r_clr + 13'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        o_rdata <= r_mem[w_addr];
    end
endmodule

FILE: hdl/chip8_instruction_core_unit.sv
// Top level of the CHIP-8 instruction core: sequencer, registers, framebuffer.
// Depends on c8_pkg, c8_mem and chip8_instruction_core_unit_assert.svh.
//
// One input beat carries an action: load a memory byte, execute one
// instruction at the program counter, or read one framebuffer row. Each
// input beat yields exactly one output beat on the result channel.
// A load or a read goes straight to S_DONE, which registers the result
// beat; an instruction first passes S_FET0, S_FET1, S_FET2 and S_EXEC.
// Sprite draw reads and then writes each row (S_DRA, S_DRB), FX55 writes
// one register per S_REG step and FX65 reads and then writes each one
// (S_REG, S_REGW), FX33 finds decimal digits by repeated subtraction,
// and 00E0 clears one row per cycle. The memory has a single port.
// The block takes one beat at a time; o_ready is low while it works.
// After reset a clearing pass over all 4096 memory bytes writes
// the font and zeros; no input beat is taken until it ends.
// A finished result sits in the output register while the next input
// beat is taken; the block stalls only if a second result would be due.
module chip8_instruction_core_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  c8_pkg::t_in   i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output c8_pkg::t_out  o_data
);
    import c8_pkg::*;
    `include "chip8_instruction_core_unit_assert.svh"

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_FET0  = 12'b000000000010,
        S_FET1  = 12'b000000000100,
        S_FET2  = 12'b000000001000,
        S_EXEC  = 12'b000000010000,
        S_CLS   = 12'b000000100000,
        S_DRA   = 12'b000001000000,
        S_DRB   = 12'b000010000000,
        S_BCD   = 12'b000100000000,
        S_REG   = 12'b001000000000,
        S_REGW  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state      r_st, n_st;
    t_in         r_in;
    logic [7:0]  r_v [0:15];
    logic [11:0] r_i, r_pc, r_next;
    logic [11:0] r_stk [0:STACK_DEPTH-1];
    logic [SP_W-1:0] r_sp;
    logic [7:0]  r_dt, r_snd;
    logic [63:0] r_fb [0:31];
    logic [15:0] r_op;
    logic [1:0]  r_status;
    logic        r_coll;
    logic [4:0]  r_cnt;
    logic [7:0]  r_acc;
    logic [1:0]  r_dig;
    logic [7:0]  r_q;
    t_out        r_out;
    logic        r_ov;

    logic        m_we;
    logic [11:0] m_addr;
    logic [7:0]  m_wdata, m_rdata;
    logic        m_busy;

    c8_mem u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wdata), .o_rdata(m_rdata), .o_busy(m_busy)
    );

    logic [3:0]  w_x, w_y, w_n;
    logic [7:0]  w_vx, w_vy, w_nn;
    logic [5:0]  w_x0;
    logic [4:0]  w_y0, w_yr;
    logic [63:0] w_mask;
    logic [8:0]  w_sum;
    logic        w_key;
    logic        w_acc_ok;

    assign w_x    = r_op[11:8];
    assign w_y    = r_op[7:4];
    assign w_n    = r_op[3:0];
    assign w_nn   = r_op[7:0];
    assign w_vx   = r_v[w_x];
    assign w_vy   = r_v[w_y];
    assign w_x0   = w_vx[5:0];
    assign w_y0   = w_vy[4:0];
    assign w_yr   = w_y0 + r_cnt;
    assign w_mask = ({56'd0, m_rdata[0], m_rdata[1], m_rdata[2], m_rdata[3],
                      m_rdata[4], m_rdata[5], m_rdata[6], m_rdata[7]}) << w_x0;
    assign w_sum  = {1'b0, w_vx} + {1'b0, w_vy};
    assign w_key  = r_in.keys_down[w_vx[3:0]];
    assign w_acc_ok = (r_dig == 2'd0) ? (r_acc >= 8'd100) : (r_acc >= 8'd10);

    assign o_ready = (r_st == S_IDLE) && !m_busy;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        m_we    = 1'b0;
        m_addr  = r_pc;
        m_wdata = 8'h00;
        priority case (1'b1)
            (r_st == S_IDLE): begin
                m_addr  = i_data.load_addr;
                m_we    = i_valid && o_ready && i_data.action == ACT_LOAD;
                m_wdata = i_data.load_data;
            end
            (r_st == S_FET0): m_addr = r_pc;
            (r_st == S_FET1): m_addr = r_pc + 12'd1;
            (r_st == S_DRA):  m_addr = r_i + 12'(r_cnt);
            (r_st == S_BCD): begin
                m_addr  = r_i + 12'(r_dig);
                m_we    = (r_dig == 2'd2) || !w_acc_ok;
                m_wdata = (r_dig == 2'd2) ? r_acc : r_q;
            end
            (r_st == S_REG): begin
                m_addr  = r_i + 12'(r_cnt);
                m_we    = (w_nn == 8'h55);
                m_wdata = r_v[r_cnt[3:0]];
            end
            default: m_addr = r_pc;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid && o_ready) begin
                n_st = (i_data.action == ACT_EXEC) ? S_FET0 : S_DONE;
            end
            S_FET0: n_st = S_FET1;
            S_FET1: n_st = S_FET2;
            S_FET2: n_st = S_EXEC;
            S_EXEC: begin
                n_st = S_DONE;
                if (r_op == 16'h00E0) n_st = S_CLS;
                else if (r_op[15:12] == 4'hD && w_n != 4'd0) n_st = S_DRA;
                else if (r_op[15:12] == 4'hF && w_nn == 8'h33) n_st = S_BCD;
                else if (r_op[15:12] == 4'hF && (w_nn == 8'h55 || w_nn == 8'h65))
                    n_st = S_REG;
            end
            S_CLS:  if (r_cnt == 5'd31) n_st = S_DONE;
            S_DRA:  n_st = S_DRB;
            S_DRB:  if (r_cnt + 5'd1 == {1'b0, w_n} || w_yr == 5'd31) n_st = S_DONE;
                    else n_st = S_DRA;
            S_BCD:  if (r_dig == 2'd2) n_st = S_DONE;
            S_REG:  n_st = (w_nn == 8'h55) ?
                        ((r_cnt[3:0] == w_x) ? S_DONE : S_REG) : S_REGW;
            S_REGW: n_st = (r_cnt[3:0] == w_x) ? S_DONE : S_REG;
            S_DONE: if (!r_ov || i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_pc  <= PROGRAM_START;
            r_i   <= '0;
            r_sp  <= '0;
            r_dt  <= '0;
            r_snd <= '0;
            r_ov  <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < 32; k++) r_fb[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DONE && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_in     <= i_data;
                    r_op     <= '0;
                    r_status <= ST_OK;
                    r_coll   <= 1'b0;
                    r_cnt    <= '0;
                    r_next   <= r_pc + 12'd2;
                end
                S_FET0: ;
                S_FET1: r_op[15:8] <= m_rdata;
                S_FET2: r_op[7:0]  <= m_rdata;
                S_EXEC: begin
                    r_acc  <= w_vx;
                    r_dig  <= 2'd0;
                    r_q    <= '0;
                    unique case (r_op[15:12])
                        4'h0: if (r_op == 16'h00EE) begin
                            if (r_sp == '0 || r_sp > SP_W'(STACK_DEPTH)) r_status <= ST_UNDER;
                            else begin
                                r_sp   <= r_sp - 1'b1;
                                r_next <= r_stk[SI_W'(r_sp - 1'b1)] + 12'd2;
                            end
                        end
                        4'h1: r_next <= r_op[11:0];
                        4'h2: if (r_sp >= SP_W'(STACK_DEPTH)) r_status <= ST_OVER;
                            else begin
                                r_stk[SI_W'(r_sp)] <= r_pc;
                                r_sp   <= r_sp + 1'b1;
                                r_next <= r_op[11:0];
                            end
                        4'h3: if (w_vx == w_nn) r_next <= r_pc + 12'd4;
                        4'h4: if (w_vx != w_nn) r_next <= r_pc + 12'd4;
                        4'h5: if (w_vx == w_vy) r_next <= r_pc + 12'd4;
                        4'h6: r_v[w_x] <= w_nn;
                        4'h7: r_v[w_x] <= w_vx + w_nn;
                        4'h8: unique case (w_n)
                            4'h0: r_v[w_x] <= w_vy;
                            4'h1: r_v[w_x] <= w_vx | w_vy;
                            4'h2: r_v[w_x] <= w_vx & w_vy;
                            4'h3: r_v[w_x] <= w_vx ^ w_vy;
                            4'h4: begin
                                if (w_x != 4'hF) r_v[w_x] <= w_sum[7:0];
                                r_v[15]  <= {7'd0, w_sum[8]};
                            end
                            4'h5: begin
                                if (w_x != 4'hF) r_v[w_x] <= w_vx - w_vy;
                                r_v[15]  <= {7'd0, w_vx >= w_vy};
                            end
                            4'h6: begin
                                if (w_x != 4'hF) r_v[w_x] <= w_vx >> 1;
                                r_v[15]  <= {7'd0, w_vx[0]};
                            end
                            4'h7: begin
                                if (w_x != 4'hF) r_v[w_x] <= w_vy - w_vx;
                                r_v[15]  <= {7'd0, w_vy >= w_vx};
                            end
                            4'hE: begin
                                if (w_x != 4'hF) r_v[w_x] <= w_vx << 1;
                                r_v[15]  <= {7'd0, w_vx[7]};
                            end
                            default: r_status <= ST_UNK;
                        endcase
                        4'h9: if (w_vx != w_vy) r_next <= r_pc + 12'd4;
                        4'hA: r_i <= r_op[11:0];
                        4'hB: r_next <= {4'd0, r_v[0]} + r_op[11:0];
                        4'hC: r_v[w_x] <= r_in.random_byte & w_nn;
                        4'hD: if (w_n == 4'd0) r_v[15] <= '0;
                        4'hE: if (w_nn == 8'h9E) begin
                                if (w_key) r_next <= r_pc + 12'd4;
                            end else if (w_nn == 8'hA1) begin
                                if (!w_key) r_next <= r_pc + 12'd4;
                            end else r_status <= ST_UNK;
                        default: unique case (w_nn)
                            8'h07: r_v[w_x] <= r_dt;
                            8'h0A, 8'h33, 8'h55, 8'h65: ;
                            8'h15: r_dt  <= w_vx;
                            8'h18: r_snd <= w_vx;
                            8'h1E: r_i <= r_i + {4'd0, w_vx};
                            8'h29: r_i <= 12'(FONT_BASE) + 12'(w_vx[3:0]) * 12'd5;
                            default: r_status <= ST_UNK;
                        endcase
                    endcase
                end
                S_CLS: begin
                    r_fb[r_cnt] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_DRA: ;
                S_DRB: begin
                    if ((r_fb[w_yr] & w_mask) != '0) r_coll <= 1'b1;
                    r_fb[w_yr] <= r_fb[w_yr] ^ w_mask;
                    r_cnt <= r_cnt + 5'd1;
                    if (n_st == S_DONE)
                        r_v[15] <= {7'd0, r_coll || ((r_fb[w_yr] & w_mask) != '0)};
                end
                S_BCD: if (r_dig != 2'd2) begin
                    if (w_acc_ok) begin
                        r_acc <= r_acc - ((r_dig == 2'd0) ? 8'd100 : 8'd10);
                        r_q   <= r_q + 8'd1;
                    end else begin
                        r_dig <= r_dig + 2'd1;
                        r_q   <= '0;
                    end
                end
                S_REG: if (w_nn == 8'h55) r_cnt <= r_cnt + 5'd1;
                S_REGW: begin
                    r_v[r_cnt[3:0]] <= m_rdata;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_DONE: if (!r_ov || i_ready) begin
                    r_out.fetched_opcode <= r_op;
                    r_out.status         <= r_status;
                    r_out.collision      <= r_coll;
                    r_out.sound_level    <= r_snd;
                    r_out.display_row    <= (r_in.action[1]) ? r_fb[r_in.row_select] : '0;
                    if (r_in.action == ACT_EXEC) begin
                        r_pc <= r_next;
                        r_out.next_pc <= r_next;
                    end else begin
                        r_out.next_pc <= r_pc;
                    end
                end
                default: ;
            endcase
        end
    end

    `C8_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !o_ready)
    `C8_ASSERT_NEXT(a_done_gives_beat, i_clk, i_rst_n, r_st == S_DONE, o_valid)
    `C8_ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= SP_W'(STACK_DEPTH))
    `C8_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && o_ready, r_st != S_IDLE)
endmodule

FILE: test/chip8_core_scoreboard.sv
`timescale 1ns / 1ps
// Opcode names shared by the testbench, and the scoreboard that predicts every result beat
// of the CHIP-8 core and compares it with what comes out. Depends on c8_pkg.
package c8_tb_pkg;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_READ_ALT = 2'd3;

    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEQI  = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SEQR  = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] MSC_GETDT = 8'h07;
    localparam logic [7:0] MSC_WAITK = 8'h0A;
    localparam logic [7:0] MSC_SETDT = 8'h15;
    localparam logic [7:0] MSC_SETST = 8'h18;
    localparam logic [7:0] MSC_ADDI  = 8'h1E;
    localparam logic [7:0] MSC_FONT  = 8'h29;
    localparam logic [7:0] MSC_BCD   = 8'h33;
    localparam logic [7:0] MSC_STORE = 8'h55;
    localparam logic [7:0] MSC_LOAD  = 8'h65;
endpackage

module chip8_core_scoreboard (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         o_ready,
    input  c8_pkg::t_in  i_data,
    input  logic         o_valid,
    input  logic         i_ready,
    input  c8_pkg::t_out o_data,
    output int           fail_count
);
    import c8_pkg::*;
    import c8_tb_pkg::*;

    logic [7:0]  mem [4096];
    logic [7:0]  vreg [16];
    logic [11:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [16];
    int          sp;
    logic [7:0]  delay_val;
    logic [7:0]  sound_val;
    logic [63:0] fb [32];
    logic [7:0]  glyph [80];
    t_out        pending_results [$];
    int          mismatches = 0;

    task clear_machine();
        int k;
        glyph = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
                  8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
                  8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
                  8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
                  8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
                  8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
                  8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
                  8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
        for (k = 0; k < 4096; k++) mem[k] = 8'h00;
        for (k = 0; k < 80; k++) mem[FONT_BASE + k] = glyph[k];
        for (k = 0; k < 16; k++) begin
            vreg[k] = 8'h00;
            stk[k] = 12'h000;
        end
        for (k = 0; k < 32; k++) fb[k] = 64'd0;
        idx = 12'h000;
        pc = PROGRAM_START;
        sp = 0;
        delay_val = 8'h00;
        sound_val = 8'h00;
    endtask

    task run_beat(input t_in d, output t_out r);
        logic [15:0] op;
        logic [3:0]  nx, ny, lo;
        logic [7:0]  nn, a, b, bits;
        logic [11:0] nnn, nxt, ad;
        logic [8:0]  sum;
        logic [5:0]  x0;
        logic [4:0]  y0;
        logic [63:0] m;
        logic        hit, key;
        int          i, j, yy, xx;
        r = '0;
        if (d.action == ACT_LOAD) begin
            mem[d.load_addr] = d.load_data;
        end else if (d.action == ACT_EXEC) begin
            op = {mem[pc], mem[pc + 12'd1]};
            nx = op[11:8];
            ny = op[7:4];
            lo = op[3:0];
            nn = op[7:0];
            nnn = op[11:0];
            nxt = pc + 12'd2;
            a = vreg[nx];
            b = vreg[ny];
            hit = 1'b0;
            case (op[15:12])
                OP_SYS: begin
                    if (op == OPC_CLS) begin
                        for (i = 0; i < 32; i++) fb[i] = 64'd0;
                    end else if (op == OPC_RET) begin
                        if (sp == 0) begin
                            r.status = ST_UNDER;
                        end else begin
                            sp--;
                            nxt = stk[sp] + 12'd2;
                        end
                    end
                end
                OP_JP: nxt = nnn;
                OP_CALL: begin
                    if (sp >= STACK_DEPTH) begin
                        r.status = ST_OVER;
                    end else begin
                        stk[sp] = pc;
                        sp++;
                        nxt = nnn;
                    end
                end
                OP_SEQI: if (a == nn) nxt = nxt + 12'd2;
                OP_SNEI: if (a != nn) nxt = nxt + 12'd2;
                OP_SEQR: if (a == b) nxt = nxt + 12'd2;
                OP_LDI: vreg[nx] = nn;
                OP_ADDI: vreg[nx] = a + nn;
                OP_ALU: begin
                    case (lo)
                        ALU_MOV: vreg[nx] = b;
                        ALU_OR:  vreg[nx] = a | b;
                        ALU_AND: vreg[nx] = a & b;
                        ALU_XOR: vreg[nx] = a ^ b;
                        ALU_ADD: begin
                            sum = {1'b0, a} + {1'b0, b};
                            vreg[nx] = sum[7:0];
                            vreg[15] = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                            vreg[nx] = a - b;
                            vreg[15] = {7'd0, a >= b};
                        end
                        ALU_SHR: begin
                            vreg[nx] = a >> 1;
                            vreg[15] = {7'd0, a[0]};
                        end
                        ALU_SUBN: begin
                            vreg[nx] = b - a;
                            vreg[15] = {7'd0, b >= a};
                        end
                        ALU_SHL: begin
                            vreg[nx] = a << 1;
                            vreg[15] = {7'd0, a[7]};
                        end
                        default: r.status = ST_UNK;
                    endcase
                end
                OP_SNER: if (a != b) nxt = nxt + 12'd2;
                OP_LDIDX: idx = nnn;
                OP_JPV0: nxt = {4'd0, vreg[0]} + nnn;
                OP_RND: vreg[nx] = d.random_byte & nn;
                OP_DRW: begin
                    x0 = a[5:0];
                    y0 = b[4:0];
                    for (i = 0; i < lo; i++) begin
                        yy = y0 + i;
                        if (yy >= 32) break;
                        ad = idx + i[11:0];
                        bits = mem[ad];
                        for (j = 0; j < 8; j++) begin
                            xx = x0 + j;
                            if (xx >= 64) break;
                            if (bits[7 - j]) begin
                                m = 64'd1 << xx;
                                if ((fb[yy] & m) != 64'd0) hit = 1'b1;
                                fb[yy] = fb[yy] ^ m;
                            end
                        end
                    end
                    vreg[15] = {7'd0, hit};
                    r.collision = hit;
                end
                OP_KEY: begin
                    key = d.keys_down[a[3:0]];
                    if (nn == KEY_DOWN) begin
                        if (key) nxt = nxt + 12'd2;
                    end else if (nn == KEY_UP) begin
                        if (!key) nxt = nxt + 12'd2;
                    end else begin
                        r.status = ST_UNK;
                    end
                end
                default: begin
                    case (nn)
                        MSC_GETDT: vreg[nx] = delay_val;
                        MSC_WAITK: ;
                        MSC_SETDT: delay_val = a;
                        MSC_SETST: sound_val = a;
                        MSC_ADDI:  idx = idx + {4'd0, a};
                        MSC_FONT:  idx = 12'(FONT_BASE + 5 * a[3:0]);
                        MSC_BCD: begin
                            mem[idx] = 8'(a / 100);
                            mem[idx + 12'd1] = 8'((a / 10) % 10);
                            mem[idx + 12'd2] = 8'(a % 10);
                        end
                        MSC_STORE: begin
                            for (i = 0; i <= nx; i++) begin
                                ad = idx + i[11:0];
                                mem[ad] = vreg[i];
                            end
                        end
                        MSC_LOAD: begin
                            for (i = 0; i <= nx; i++) begin
                                ad = idx + i[11:0];
                                vreg[i] = mem[ad];
                            end
                        end
                        default: r.status = ST_UNK;
                    endcase
                end
            endcase
            pc = nxt;
            r.fetched_opcode = op;
        end else begin
            r.display_row = fb[d.row_select];
        end
        r.next_pc = pc;
        r.sound_level = sound_val;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            clear_machine();
            pending_results.delete();
        end else begin
            if (i_valid && o_ready) begin
                run_beat(i_data, want);
                pending_results.push_back(want);
            end
            if (o_valid && i_ready) begin
                got = o_data;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with none expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_pc !== want.next_pc) begin
                        $display("%0t: next_pc expected %h actual %h",
                                 $time, want.next_pc, got.next_pc);
                        mismatches++;
                    end
                    if (got.fetched_opcode !== want.fetched_opcode) begin
                        $display("%0t: fetched_opcode expected %h actual %h",
                                 $time, want.fetched_opcode, got.fetched_opcode);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %h actual %h",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.collision !== want.collision) begin
                        $display("%0t: collision expected %h actual %h",
                                 $time, want.collision, got.collision);
                        mismatches++;
                    end
                    if (got.display_row !== want.display_row) begin
                        $display("%0t: display_row expected %h actual %h",
                                 $time, want.display_row, got.display_row);
                        mismatches++;
                    end
                    if (got.sound_level !== want.sound_level) begin
                        $display("%0t: sound_level expected %h actual %h",
                                 $time, want.sound_level, got.sound_level);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches + pending_results.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for chip8_instruction_core_unit: clock, reset, stimulus and verdict.
// Depends on c8_pkg, c8_tb_pkg, chip8_core_scoreboard and chip8_instruction_core_unit.
module tb;
    import c8_pkg::*;
    import c8_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    int          fail_count;

    int          tx_pct = 0;
    int          rx_pct = 0;
    int          hold_left = 0;
    int          sent_cnt = 0;
    int          done_cnt = 0;
    logic [11:0] last_pc = PROGRAM_START;

    chip8_instruction_core_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    chip8_core_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .fail_count(fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_pct);
        end
        if (i_rst_n && o_valid && i_ready) begin
            done_cnt <= done_cnt + 1;
            last_pc <= o_data.next_pc;
        end
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    function t_in rand_fields();
        t_in t;
        t.action = 2'($urandom_range(3));
        t.load_addr = 12'($urandom_range(4095));
        t.load_data = 8'($urandom_range(255));
        t.keys_down = 16'($urandom_range(65535));
        t.random_byte = 8'($urandom_range(255));
        t.row_select = 5'($urandom_range(31));
        return t;
    endfunction

    function logic [15:0] rand_op();
        logic [3:0]  cls;
        logic [11:0] arg;
        logic [3:0]  alu_ops [9];
        logic [7:0]  misc_ops [9];
        alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_SUBN, ALU_SHL};
        misc_ops = '{MSC_GETDT, MSC_WAITK, MSC_SETDT, MSC_SETST, MSC_ADDI, MSC_FONT,
                     MSC_BCD, MSC_STORE, MSC_LOAD};
        cls = 4'($urandom_range(15));
        arg = 12'($urandom_range(4095));
        case (cls)
            OP_SYS: begin
                case ($urandom_range(2))
                    0: return OPC_CLS;
                    1: return OPC_RET;
                    default: return {OP_SYS, arg};
                endcase
            end
            OP_ALU:
                if ($urandom_range(9) != 0) arg[3:0] = alu_ops[$urandom_range(8)];
            OP_KEY:
                if ($urandom_range(9) != 0) arg[7:0] = $urandom_range(1) ? KEY_DOWN : KEY_UP;
            OP_MISC:
                if ($urandom_range(9) != 0) arg[7:0] = misc_ops[$urandom_range(8)];
            default: ;
        endcase
        return {cls, arg};
    endfunction

    task pause_tx();
        if ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_pct);
        end
    endtask

    task push_beat(input t_in d);
        pause_tx();
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    task wait_drained();
        if (sent_cnt != done_cnt) begin
            i_valid <= 1'b0;
            while (sent_cnt != done_cnt) @(posedge i_clk);
        end
    endtask

    task push_action(input logic [1:0] act);
        t_in t;
        t = rand_fields();
        t.action = act;
        push_beat(t);
    endtask

    task push_load(input logic [11:0] addr, input logic [7:0] data);
        t_in t;
        t = rand_fields();
        t.action = ACT_LOAD;
        t.load_addr = addr;
        t.load_data = data;
        push_beat(t);
    endtask

    // Places one instruction at the current program counter and runs it.
    task exec_at(input logic [15:0] op);
        logic [11:0] at;
        wait_drained();
        at = last_pc;
        push_load(at, op[15:8]);
        push_load(at + 12'd1, op[7:0]);
        push_action(ACT_EXEC);
    endtask

    task push_noise();
        t_in t;
        t = rand_fields();
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
                t.action = ACT_LOAD;
                if ($urandom_range(1)) t.load_addr = last_pc + 12'($urandom_range(7));
            end
            8, 9, 10, 11, 12, 13, 14, 15: t.action = ACT_EXEC;
            16, 17, 18: t.action = ACT_READ;
            default: t.action = ACT_READ_ALT;
        endcase
        push_beat(t);
    endtask

    initial begin
        int ph;
        int n;
        int k;
        t_in t;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        exec_at(OPC_RET);
        exec_at(OPC_CLS);
        exec_at({OP_LDI, 4'hA, 8'hFF});
        exec_at({OP_LDI, 4'hB, 8'h01});
        exec_at({OP_ALU, 4'hA, 4'hB, ALU_ADD});
        exec_at({OP_ALU, 4'hA, 4'hB, ALU_SUB});
        exec_at({OP_ALU, 4'hB, 4'hA, ALU_SUBN});
        exec_at({OP_ALU, 4'hF, 4'hA, ALU_SHL});
        exec_at({OP_ALU, 4'hA, 4'hB, 4'h9});
        exec_at({OP_KEY, 4'h0, 8'hFF});
        exec_at({OP_MISC, 4'h0, 8'hFF});
        exec_at({OP_LDI, 4'h0, 8'h3E});
        exec_at({OP_LDI, 4'h1, 8'h1E});
        exec_at({OP_LDIDX, 12'h050});
        exec_at({OP_DRW, 4'h0, 4'h1, 4'hF});
        exec_at({OP_DRW, 4'h0, 4'h1, 4'hF});
        exec_at({OP_MISC, 4'hA, MSC_BCD});
        exec_at({OP_MISC, 4'hF, MSC_STORE});
        exec_at({OP_MISC, 4'hF, MSC_LOAD});
        exec_at({OP_RND, 4'h2, 8'hFF});
        exec_at({OP_JP, 12'hFFF});
        exec_at({OP_JPV0, 12'hFFF});
        t = rand_fields();
        t.action = ACT_READ;
        t.row_select = 5'd31;
        push_beat(t);
        t.action = ACT_READ_ALT;
        t.row_select = 5'd30;
        push_beat(t);
        push_load(12'hFFF, 8'hFF);

        // A call to itself fills the stack and then overflows it.
        wait_drained();
        exec_at({OP_CALL, last_pc});
        for (k = 0; k < 16; k++) push_action(ACT_EXEC);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 87; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 87; end
                3: begin tx_pct = 32; rx_pct = 32; end
                default: begin tx_pct = 0; rx_pct = 0; end
            endcase
            n = 0;
            while (n < 250) begin
                if (ph == 0 && n >= 100 && n < 103) begin
                    hold_left = 400;
                    for (k = 0; k < 30; k++) push_noise();
                    n += 30;
                end else if ($urandom_range(99) < 65) begin
                    exec_at(rand_op());
                    n += 3;
                end else begin
                    push_noise();
                    n += 1;
                end
            end
        end

        i_valid <= 1'b0;
        while (sent_cnt != done_cnt) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/c8_pkg.sv
hdl/c8_mem.sv
hdl/chip8_instruction_core_unit.sv
test/chip8_core_scoreboard.sv
test/tb.sv
